// ===== rtl/core/bsm_pkg.sv =====
package bsm_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int ACC_W         = OPERAND_WIDTH + 1;
	localparam int FIELD_W       = 32;
	localparam int PRODUCT_W     = 64;

	localparam logic [1:0] BOOTH_SUB = 2'b10;
	localparam logic [1:0] BOOTH_ADD = 2'b01;

	typedef struct packed {
		logic signed [ACC_W-1:0]  acc;
		logic [OPERAND_WIDTH-1:0] mq;
		logic                     prev;
		logic signed [ACC_W-1:0]  mcand;
	} bsm_stage_t;

endpackage

// ===== rtl/core/bsm_booth_step.sv =====
module bsm_booth_step import bsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  bsm_stage_t in_data,
	output logic       in_ready,
	output logic       out_valid,
	output bsm_stage_t out_data,
	input  logic       out_ready
);

	logic                    valid_s1;
	bsm_stage_t              data_s1;
	logic signed [ACC_W-1:0] sum;
	bsm_stage_t              next_data;

	always_comb begin
		case ({in_data.mq[0], in_data.prev})
			BOOTH_SUB: sum = in_data.acc - in_data.mcand;
			BOOTH_ADD: sum = in_data.acc + in_data.mcand;
			default:   sum = in_data.acc;
		endcase
		next_data.acc   = {sum[ACC_W-1], sum[ACC_W-1:1]};
		next_data.mq    = {sum[0], in_data.mq[OPERAND_WIDTH-1:1]};
		next_data.prev  = in_data.mq[0];
		next_data.mcand = in_data.mcand;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= next_data;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== rtl/core/booth_signed_multiplier.sv =====
// Signed radix-2 Booth multiplier, fully pipelined. Each request carries a
// signed multiplicand and multiplier; the low OPERAND_WIDTH bits of each are
// used as two's complement operands and the exact product comes out
// sign-extended to 64 bits. There is one register stage per Booth step, and
// a new request is taken every cycle while in_stall is low. Each stage holds
// its item only while the stage after it is full and blocked, so empty
// stages fill even while the output is stalled. No state survives between
// requests.
module booth_signed_multiplier import bsm_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [FIELD_W-1:0]   multiplicand_in,
	input  logic signed [FIELD_W-1:0]   multiplier_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [PRODUCT_W-1:0] product_out
);

	bsm_stage_t                           node_data [OPERAND_WIDTH+1];
	logic [OPERAND_WIDTH:0]               node_valid;
	logic [OPERAND_WIDTH:0]               node_ready;
	logic signed [ACC_W+OPERAND_WIDTH-1:0] full_product;

	assign node_valid[0]       = in_valid;
	assign node_data[0].acc    = '0;
	assign node_data[0].mq     = multiplier_in[OPERAND_WIDTH-1:0];
	assign node_data[0].prev   = 1'b0;
	assign node_data[0].mcand  = {multiplicand_in[OPERAND_WIDTH-1],
		multiplicand_in[OPERAND_WIDTH-1:0]};

	genvar k;
	generate
		for (k = 0; k < OPERAND_WIDTH; k++) begin : g_step
			bsm_booth_step u_step (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (node_valid[k]),
				.in_data   (node_data[k]),
				.in_ready  (node_ready[k]),
				.out_valid (node_valid[k+1]),
				.out_data  (node_data[k+1]),
				.out_ready (node_ready[k+1])
			);
		end
	endgenerate

	assign node_ready[OPERAND_WIDTH] = !out_stall;
	assign in_stall                  = !node_ready[0];
	assign out_valid                 = node_valid[OPERAND_WIDTH];

	assign full_product = {node_data[OPERAND_WIDTH].acc, node_data[OPERAND_WIDTH].mq};
	assign product_out  = PRODUCT_W'(full_product);

endmodule
